// File: hdl/lcm_pkg.sv
// Shared types and constants for the LRU chunk mapper.
// No dependencies; imported by lcm_cell and lru_chunk_mapper_core.
package lcm_pkg;

    localparam int NUM_CHUNKS_DEF = 128;
    localparam int STAMP_BITS_DEF = 32;

    // Width of the resident limit register and its value after reset.
    localparam int         LIMIT_W         = 8;
    localparam logic [7:0] MAX_RESIDENT_RST = 8'd78;

    // Control bits of the search wave that travels down the cell row.
    typedef struct packed {
        logic valid;
        logic found;
    } lcm_wave_t;

    // Per-cell update strobes issued when a request commits.
    typedef struct packed {
        logic set;
        logic clear;
    } lcm_cell_ctl_t;

endpackage

// File: hdl/lru_chunk_mapper_core.sv
// LRU chunk mapper top level: request control, resident count and the cell row.
// A hit or a miss below the limit goes from the decision state straight to commit;
// a miss at the limit first runs the victim search, which walks the row one cell
// per cycle. One request in work: a new one is accepted only back in idle, and
// commit waits while a finished result is held at the output by out_stall.
// Reset (rst_n, async, active low): no chunk resident, counters zero, limit 78.
module lru_chunk_mapper_core
    import lcm_pkg::*;
#(
    parameter int NUM_CHUNKS = NUM_CHUNKS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF,
    parameter int CHUNK_W    = $clog2(NUM_CHUNKS),
    parameter int CNT_W      = $clog2(NUM_CHUNKS + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CHUNK_W-1:0] chunk,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic               evicted,
    output logic [CHUNK_W-1:0] victim,
    output logic [CNT_W-1:0]   resident_count,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] max_resident
);

    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECIDE = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CHUNK_W-1:0]    chunk_reg;
    logic                  ignore_reg, ignore_next;
    logic                  hit_reg, hit_next;
    logic                  evict_reg, evict_next;
    logic [CHUNK_W-1:0]    victim_reg, victim_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [STAMP_BITS-1:0] stamp_cnt_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic                  out_evict_reg;
    logic [CHUNK_W-1:0]    out_victim_reg;
    logic [CNT_W-1:0]      out_count_reg;

    logic                  in_fire;
    logic                  commit_fire;
    logic                  at_limit;
    logic                  lookup_hit;
    logic                  search_start;
    logic [NUM_CHUNKS-1:0] resident_vec;

    lcm_wave_t             wave   [NUM_CHUNKS+1];
    logic [STAMP_BITS-1:0] best   [NUM_CHUNKS+1];
    logic [CHUNK_W-1:0]    bestix [NUM_CHUNKS+1];

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_fire     = in_valid && !in_stall;
    assign commit_fire = (state_reg == ST_COMMIT) && (!out_valid_reg || !out_stall);
    assign cfg_ready   = 1'b1;

    assign ignore_next = ({1'b0, chunk_reg} >= (CHUNK_W+1)'(NUM_CHUNKS));
    assign lookup_hit  = !ignore_next && resident_vec[chunk_reg];
    assign at_limit    = CMP_W'(count_reg) >= CMP_W'(limit_reg);
    assign search_start = (state_reg == ST_DECIDE) && !ignore_next && !lookup_hit
                          && at_limit;

    // The search wave enters the first cell with no candidate yet.
    assign wave[0].valid = search_start;
    assign wave[0].found = 1'b0;
    assign best[0]       = '0;
    assign bestix[0]     = '0;

    for (genvar i = 0; i < NUM_CHUNKS; i++)
    begin : g_cell
        lcm_cell_ctl_t cell_ctl;

        assign cell_ctl.set   = commit_fire && !ignore_reg && (chunk_reg == CHUNK_W'(i));
        assign cell_ctl.clear = commit_fire && evict_reg && (victim_reg == CHUNK_W'(i));

        lcm_cell #(
            .STAMP_BITS (STAMP_BITS),
            .CHUNK_W    (CHUNK_W),
            .CELL_IDX   (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (cell_ctl),
            .wr_stamp     (stamp_cnt_reg),
            .resident     (resident_vec[i]),
            .wave_in      (wave[i]),
            .best_in      (best[i]),
            .best_idx_in  (bestix[i]),
            .wave_out     (wave[i+1]),
            .best_out     (best[i+1]),
            .best_idx_out (bestix[i+1])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        hit_next    = hit_reg;
        evict_next  = evict_reg;
        victim_next = victim_reg;
        count_next  = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                hit_next    = lookup_hit;
                evict_next  = 1'b0;
                victim_next = '0;
                state_next  = search_start ? ST_SEARCH : ST_COMMIT;
            end
            ST_SEARCH:
            begin
                if (wave[NUM_CHUNKS].valid)
                begin
                    evict_next  = wave[NUM_CHUNKS].found;
                    victim_next = wave[NUM_CHUNKS].found ? bestix[NUM_CHUNKS] : '0;
                    state_next  = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (commit_fire)
                begin
                    if (!ignore_reg && !hit_reg)
                    begin
                        count_next = count_reg + CNT_W'(1) - CNT_W'(evict_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            stamp_cnt_reg <= '0;
            limit_reg     <= MAX_RESIDENT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= max_resident;
            end
            if (commit_fire && !ignore_reg)
            begin
                stamp_cnt_reg <= stamp_cnt_reg + STAMP_BITS'(1);
            end
            if (commit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg    <= hit_next;
        evict_reg  <= evict_next;
        victim_reg <= victim_next;
        if (in_fire)
        begin
            chunk_reg <= chunk;
        end
        if (state_reg == ST_DECIDE)
        begin
            ignore_reg <= ignore_next;
        end
        if (commit_fire)
        begin
            out_hit_reg    <= hit_reg;
            out_evict_reg  <= evict_reg;
            out_victim_reg <= victim_reg;
            out_count_reg  <= count_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = out_hit_reg;
    assign evicted        = out_evict_reg;
    assign victim         = out_victim_reg;
    assign resident_count = out_count_reg;

    // The resident count always matches the number of resident cells.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(resident_vec) == int'(count_reg))
        else $error("resident count differs from resident cells");

    // An eviction always removes a chunk that is resident.
    a_victim_resident: assert property (@(posedge clk) disable iff (!rst_n)
        commit_fire && evict_reg |-> resident_vec[victim_reg])
        else $error("evicting a chunk that is not resident");

    // A hit never evicts.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_evict_reg))
        else $error("hit reported together with an eviction");

    // A search starts only from the decision step and ends in commit.
    a_search_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) && wave[NUM_CHUNKS].valid |=> (state_reg == ST_COMMIT))
        else $error("search result not followed by commit");

endmodule

// File: hdl/lcm_cell.sv
// One cell of the LRU row: holds the resident flag and use stamp of one chunk.
// Forwards the running minimum-stamp candidate to its neighbor. Uses lcm_pkg.
module lcm_cell
    import lcm_pkg::*;
#(
    parameter int STAMP_BITS = STAMP_BITS_DEF,
    parameter int CHUNK_W    = $clog2(NUM_CHUNKS_DEF),
    parameter int CELL_IDX   = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcm_cell_ctl_t         ctl,
    input  logic [STAMP_BITS-1:0] wr_stamp,
    output logic                  resident,
    input  lcm_wave_t             wave_in,
    input  logic [STAMP_BITS-1:0] best_in,
    input  logic [CHUNK_W-1:0]    best_idx_in,
    output lcm_wave_t             wave_out,
    output logic [STAMP_BITS-1:0] best_out,
    output logic [CHUNK_W-1:0]    best_idx_out
);

    logic                  resident_reg;
    logic [STAMP_BITS-1:0] stamp_reg;
    lcm_wave_t             wave_reg;
    lcm_wave_t             wave_next;
    logic [STAMP_BITS-1:0] best_reg;
    logic [STAMP_BITS-1:0] best_next;
    logic [CHUNK_W-1:0]    best_idx_reg;
    logic [CHUNK_W-1:0]    best_idx_next;
    logic                  take;

    // The first resident chunk with the smallest stamp wins, so only a
    // strictly smaller stamp replaces an earlier candidate.
    assign take = resident_reg && (!wave_in.found || (stamp_reg < best_in));

    always_comb
    begin
        wave_next.valid = wave_in.valid;
        wave_next.found = wave_in.found | resident_reg;
        best_next       = take ? stamp_reg : best_in;
        best_idx_next   = take ? CHUNK_W'(CELL_IDX) : best_idx_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resident_reg <= 1'b0;
            wave_reg     <= '0;
        end
        else
        begin
            if (ctl.set)
            begin
                resident_reg <= 1'b1;
            end
            else if (ctl.clear)
            begin
                resident_reg <= 1'b0;
            end
            wave_reg <= wave_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.set)
        begin
            stamp_reg <= wr_stamp;
        end
        if (wave_in.valid)
        begin
            best_reg     <= best_next;
            best_idx_reg <= best_idx_next;
        end
    end

    assign resident     = resident_reg;
    assign wave_out     = wave_reg;
    assign best_out     = best_reg;
    assign best_idx_out = best_idx_reg;

endmodule
